[rtl/zia_pkg.sv]
// Types, constants and codes shared by the zone intrusion alarm.
`default_nettype none

package zia_pkg;

  // Build-time sizing
  localparam int NUM_CAMERAS = 4;
  localparam int COUNT_BITS  = 24;

  // Fixed field widths
  localparam int CAM_W      = 2;
  localparam int CONF_W     = 11;
  localparam int BOX_W      = 12;
  localparam int MASK_W     = 8;
  localparam int PIX_THR_W  = 24;
  localparam int HOLD_W     = 16;
  localparam int ELAPSED_W  = 16;
  localparam int LEVEL_W    = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  // Camera addressing into the per-camera state memory
  localparam int CAM_AW = (NUM_CAMERAS > 1) ? $clog2(NUM_CAMERAS) : 1;
  // Wide enough to hold the camera field and the value NUM_CAMERAS itself
  localparam int CAM_CW = $clog2(NUM_CAMERAS + 1);
  localparam int CAM_XW = (CAM_CW > CAM_W) ? CAM_CW : CAM_W;

  // Width used to compare a pixel count with the pixel threshold
  localparam int CMP_W = (COUNT_BITS > PIX_THR_W) ? COUNT_BITS : PIX_THR_W;

  localparam logic [BOX_W-1:0]  MIN_BOX_SIDE   = BOX_W'(15);
  localparam logic [MASK_W-1:0] MASK_SET_LIMIT = MASK_W'(127);

  // Register reset values
  localparam logic [CONF_W-1:0]    CONF_THR_RST = CONF_W'(512);
  localparam logic [PIX_THR_W-1:0] PIX_THR_RST  = PIX_THR_W'(100);
  localparam logic [HOLD_W-1:0]    HOLD_RST     = HOLD_W'(1000);

  typedef enum logic [1:0] {
    FN_TICK       = 2'd0,
    FN_PIXEL      = 2'd1,
    FN_END_TARGET = 2'd2,
    FN_END_FRAME  = 2'd3
  } func_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CONF_THR = 2'd0,
    CFG_PIX_THR  = 2'd1,
    CFG_HOLD     = 2'd2
  } cfg_reg_t;

  localparam logic [LEVEL_W-1:0] LVL_SAFE  = 2'd0;
  localparam logic [LEVEL_W-1:0] LVL_DECEL = 2'd1;
  localparam logic [LEVEL_W-1:0] LVL_STOP  = 2'd2;

  typedef struct packed {
    func_t             func;
    logic [CAM_W-1:0]  camera;
    logic              in_stop_zone;
    logic              in_decel_zone;
    logic [MASK_W-1:0] mask_value;
    logic [CONF_W-1:0] confidence;
    logic [BOX_W-1:0]  box_width;
    logic [BOX_W-1:0]  box_height;
    logic              mask_fits_box;
  } item_t;

  typedef struct packed {
    logic [CAM_W-1:0]   result_camera;
    logic [LEVEL_W-1:0] level;
    logic               snapshot;
    logic               level_changed;
    logic               stop_hit;
    logic               decel_hit;
  } result_t;

  // One entry of the per-camera state memory
  typedef struct packed {
    logic [LEVEL_W-1:0] prev_level;
    logic               stop_hit;
    logic               decel_hit;
  } cam_state_t;

endpackage

`default_nettype wire

[rtl/zone_intrusion_alarm.sv]
// Zone intrusion alarm: per-camera level judgment over a stream of detection beats.
//
//  channel  | handshake              | payload              | direction
//  ---------+------------------------+----------------------+----------
//  item     | item_valid / item_stall| item   (item_t)      | in
//  result   | result_valid /         | result (result_t)    | out
//           |   result_stall         |                      |
//  config   | wr_en                  | wr_index, wr_data    | in
//
// One item beat per cycle sustained while item_stall is low. An accepted item
// enters the work stage as its state entry is read; the work stage writes the
// entry back at the same edge as it registers a frame-end result for output.
// The memory's single write port and the forward path from a write-back to a
// read in the same cycle keep back-to-back beats on one camera correct.
// Reset (rst, synchronous) restores the registers, sets all hold timers to
// the far past and clears the memory's valid bits; no clearing pass is run.
// A stalled result holds; an end-of-frame beat waiting behind it holds the
// work stage, and only then is item_stall raised.
`default_nettype none

module zone_intrusion_alarm
  import zia_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  // item channel
  input  wire logic                  item_valid,
  output logic                       item_stall,
  input  wire item_t                 item,
  // result channel
  output logic                       result_valid,
  input  wire logic                  result_stall,
  output result_t                    result,
  // configuration writes
  input  wire logic                  wr_en,
  input  wire logic [CFG_IDX_W-1:0]  wr_index,
  input  wire logic [CFG_DATA_W-1:0] wr_data
);

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [CONF_W-1:0]    conf_thr;
  logic [PIX_THR_W-1:0] pix_thr;
  logic [HOLD_W-1:0]    hold_ms;

  always_ff @(posedge clk) begin
    if (rst) begin
      conf_thr <= CONF_THR_RST;
      pix_thr  <= PIX_THR_RST;
      hold_ms  <= HOLD_RST;
    end else if (wr_en) begin
      unique case (cfg_reg_t'(wr_index))
        CFG_CONF_THR: conf_thr <= wr_data[CONF_W-1:0];
        CFG_PIX_THR:  pix_thr  <= wr_data[PIX_THR_W-1:0];
        CFG_HOLD:     hold_ms  <= wr_data[HOLD_W-1:0];
        default: ;  // unmapped index: drop the write
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Handshake and work stage
  // ---------------------------------------------------------------------
  logic       s1_valid;
  item_t      s1_item;
  logic       s1_fire;
  logic       s1_is_frame;
  logic       out_free;
  logic       accept;

  logic [CAM_XW-1:0] s1_cam_ext;
  logic              s1_cam_ok;
  logic [CAM_AW-1:0] s1_idx;

  logic [CAM_XW-1:0] in_cam_ext;
  logic [CAM_AW-1:0] in_idx;

  assign in_cam_ext = CAM_XW'(item.camera);
  assign in_idx     = in_cam_ext[CAM_AW-1:0];

  assign s1_cam_ext  = CAM_XW'(s1_item.camera);
  assign s1_cam_ok   = s1_cam_ext < CAM_XW'(NUM_CAMERAS);
  assign s1_idx      = s1_cam_ext[CAM_AW-1:0];
  assign s1_is_frame = (s1_item.func == FN_END_FRAME) && s1_cam_ok;

  assign out_free   = !result_valid || !result_stall;
  // Only a frame-end beat for an existing camera needs the output slot; everything else retires.
  assign s1_fire    = s1_valid && (out_free || !s1_is_frame);
  assign item_stall = s1_valid && !s1_fire;
  assign accept     = item_valid && !item_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item <= item;
    end
  end

  // ---------------------------------------------------------------------
  // Per-camera state memory: read at accept, write back from the work stage
  // ---------------------------------------------------------------------
  cam_state_t                 mem [NUM_CAMERAS];
  logic [NUM_CAMERAS-1:0]     mem_ok;      // entry written since reset
  cam_state_t                 rd_data;
  logic                       rd_ok;
  logic                       fwd_hit;
  cam_state_t                 fwd_data;
  logic                       mem_we;
  cam_state_t                 st_cur;
  cam_state_t                 st_next;

  assign mem_we = s1_fire && s1_cam_ok &&
                  (s1_item.func == FN_END_TARGET || s1_item.func == FN_END_FRAME);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[s1_idx] <= st_next;
    end
    if (accept) begin
      rd_data  <= mem[in_idx];
      fwd_data <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mem_ok  <= '0;
      rd_ok   <= 1'b0;
      fwd_hit <= 1'b0;
    end else begin
      if (mem_we) begin
        mem_ok[s1_idx] <= 1'b1;
      end
      if (accept) begin
        rd_ok   <= mem_ok[in_idx];
        // Write-back to the entry being read in the same cycle: forward it.
        fwd_hit <= mem_we && (s1_idx == in_idx);
      end
    end
  end

  // An entry never written reads as its reset value: safe, no hits.
  always_comb begin
    if (fwd_hit) begin
      st_cur = fwd_data;
    end else if (rd_ok) begin
      st_cur = rd_data;
    end else begin
      st_cur = '0;
    end
  end

  // ---------------------------------------------------------------------
  // Target pixel counters and hold timers
  // ---------------------------------------------------------------------
  logic [COUNT_BITS-1:0] stop_count;
  logic [COUNT_BITS-1:0] decel_count;
  logic [ELAPSED_W-1:0]  stop_el  [NUM_CAMERAS];
  logic [ELAPSED_W-1:0]  decel_el [NUM_CAMERAS];

  logic pix_set;
  logic qualified;
  logic stop_int;
  logic decel_int;
  logic hit_stop;
  logic hit_decel;

  assign pix_set   = s1_item.mask_value > MASK_SET_LIMIT;
  assign qualified = s1_cam_ok && (s1_item.confidence >= conf_thr) &&
                     (s1_item.box_width >= MIN_BOX_SIDE) &&
                     (s1_item.box_height >= MIN_BOX_SIDE) && s1_item.mask_fits_box;
  assign stop_int  = CMP_W'(stop_count) > CMP_W'(pix_thr);
  assign decel_int = CMP_W'(decel_count) > CMP_W'(pix_thr);
  // A stop intrusion masks the decel test.
  assign hit_stop  = qualified && stop_int;
  assign hit_decel = qualified && !stop_int && decel_int;

  always_ff @(posedge clk) begin
    if (rst) begin
      stop_count  <= '0;
      decel_count <= '0;
    end else if (s1_fire) begin
      unique case (s1_item.func)
        FN_PIXEL: begin
          if (pix_set && s1_item.in_stop_zone && !(&stop_count)) begin
            stop_count <= stop_count + 1'b1;
          end
          if (pix_set && s1_item.in_decel_zone && !(&decel_count)) begin
            decel_count <= decel_count + 1'b1;
          end
        end
        FN_END_TARGET: begin
          stop_count  <= '0;
          decel_count <= '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < NUM_CAMERAS; c++) begin
        stop_el[c]  <= '1;
        decel_el[c] <= '1;
      end
    end else if (s1_fire) begin
      if (s1_item.func == FN_TICK) begin
        // Advance every camera's timers, saturating at the far past.
        for (int c = 0; c < NUM_CAMERAS; c++) begin
          if (!(&stop_el[c])) begin
            stop_el[c] <= stop_el[c] + 1'b1;
          end
          if (!(&decel_el[c])) begin
            decel_el[c] <= decel_el[c] + 1'b1;
          end
        end
      end else if (s1_item.func == FN_END_TARGET) begin
        if (hit_stop) begin
          stop_el[s1_idx] <= '0;
        end else if (hit_decel) begin
          decel_el[s1_idx] <= '0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Frame judgment and state write-back
  // ---------------------------------------------------------------------
  logic               f_stop;
  logic               f_decel;
  logic [LEVEL_W-1:0] judged_level;
  logic               snap;

  assign f_stop       = stop_el[s1_idx] < hold_ms;
  assign f_decel      = !f_stop && (decel_el[s1_idx] < hold_ms);
  assign judged_level = f_stop ? LVL_STOP : (f_decel ? LVL_DECEL : LVL_SAFE);
  assign snap         = (f_stop && (st_cur.prev_level != LVL_STOP) && st_cur.stop_hit) ||
                        (f_decel && (st_cur.prev_level == LVL_SAFE) && st_cur.decel_hit);

  always_comb begin
    st_next = st_cur;
    if (s1_item.func == FN_END_FRAME) begin
      // Record the level, drop the frame's hit flags.
      st_next.prev_level = judged_level;
      st_next.stop_hit   = 1'b0;
      st_next.decel_hit  = 1'b0;
    end else begin
      st_next.stop_hit  = st_cur.stop_hit  | hit_stop;
      st_next.decel_hit = st_cur.decel_hit | hit_decel;
    end
  end

  // ---------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s1_fire && s1_is_frame) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_is_frame) begin
      result.result_camera <= s1_item.camera;
      result.level         <= judged_level;
      result.snapshot      <= snap;
      result.level_changed <= judged_level != st_cur.prev_level;
      result.stop_hit      <= st_cur.stop_hit;
      result.decel_hit     <= st_cur.decel_hit;
    end
  end

`ifndef SYNTHESIS
  a_stall_only_on_frame: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> (s1_valid && s1_is_frame && result_valid && result_stall))
    else $error("item stall without a blocked frame-end beat");

  a_snap_changes_level: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (!result.snapshot || result.level_changed))
    else $error("snapshot without a level change");

  a_snap_needs_hit: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.snapshot) |-> (result.stop_hit || result.decel_hit))
    else $error("snapshot without an intrusion in the frame");

  a_counts_cleared: assert property (@(posedge clk) disable iff (rst)
    (s1_fire && s1_item.func == FN_END_TARGET) |=> (stop_count == '0 && decel_count == '0))
    else $error("pixel counts not cleared after end of target");
`endif

endmodule

`default_nettype wire

[tb/zone_intrusion_alarm_test.sv]
// Self-checking testbench for the zone intrusion alarm: predicts every frame verdict and compares.
module zone_intrusion_alarm_test
  import zia_pkg::*;
();

  // Cycles with no beat moving on either channel before the run is called hung
  localparam int IDLE_LIMIT    = 2000;
  // Margin after the pipeline drains, before a register write
  localparam int SETTLE_CYCLES = 6;
  localparam int ITEM_W        = $bits(item_t);

  logic                  clk          = 1'b0;
  logic                  rst          = 1'b1;
  logic                  item_valid   = 1'b0;
  logic                  item_stall;
  item_t                 item         = '0;
  logic                  result_valid;
  logic                  result_stall = 1'b0;
  result_t               result;
  logic                  wr_en        = 1'b0;
  logic [CFG_IDX_W-1:0]  wr_index     = '0;
  logic [CFG_DATA_W-1:0] wr_data      = '0;

  zone_intrusion_alarm DUT (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .wr_en        (wr_en),
    .wr_index     (wr_index),
    .wr_data      (wr_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Alarm predictor state: a shadow of the registers and of every camera's
  // hold timers, last level and per-frame hit flags.
  // ---------------------------------------------------------------------------
  logic [CONF_W-1:0]     thr_conf;
  logic [PIX_THR_W-1:0]  thr_pix;
  logic [HOLD_W-1:0]     hold_len;
  logic [COUNT_BITS-1:0] stop_px;
  logic [COUNT_BITS-1:0] decel_px;
  logic [ELAPSED_W-1:0]  stop_age   [NUM_CAMERAS];
  logic [ELAPSED_W-1:0]  decel_age  [NUM_CAMERAS];
  logic [LEVEL_W-1:0]    last_level [NUM_CAMERAS];
  logic                  saw_stop   [NUM_CAMERAS];
  logic                  saw_decel  [NUM_CAMERAS];

  result_t verdicts_due[$];   // verdicts predicted but not yet seen
  item_t   pending[$];        // beats waiting for the driver

  int items_taken      = 0;
  int verdicts_checked = 0;
  int stop_verdicts    = 0;
  int decel_verdicts   = 0;
  int snapshots        = 0;
  int fails            = 0;

  logic [31:0] cycle_no = '0;
  logic        calm;
  int          gap_left   = 0;
  int          stall_left = 0;
  int          idle_run   = 0;

  // A quarter of the time neither side idles, so full-rate stretches occur
  assign calm = (cycle_no[8:7] == 2'b11);

  // Idle length for either side: mostly none or short, now and then long
  function automatic int pause_len();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Advance the shadow state by one accepted beat; queue a verdict at frame end
  task automatic judge_item(input item_t it);
    logic    hold_stop;
    logic    hold_decel;
    logic    qualified;
    result_t v;
    case (it.func)
      FN_TICK: begin
        // every camera ages, whatever the camera field says
        for (int k = 0; k < NUM_CAMERAS; k++) begin
          if (stop_age[k] != '1) stop_age[k] = stop_age[k] + 1'b1;
          if (decel_age[k] != '1) decel_age[k] = decel_age[k] + 1'b1;
        end
      end
      FN_PIXEL: begin
        if (it.mask_value > MASK_SET_LIMIT) begin
          if (it.in_stop_zone && stop_px != '1) stop_px = stop_px + 1'b1;
          if (it.in_decel_zone && decel_px != '1) decel_px = decel_px + 1'b1;
        end
      end
      FN_END_TARGET: begin
        qualified = (it.camera < NUM_CAMERAS) && (it.confidence >= thr_conf) &&
                    (it.box_width >= MIN_BOX_SIDE) && (it.box_height >= MIN_BOX_SIDE) &&
                    it.mask_fits_box;
        // a stop intrusion shadows the decel test for the same target
        if (qualified) begin
          if (stop_px > thr_pix) begin
            saw_stop[it.camera] = 1'b1;
            stop_age[it.camera] = '0;
          end else if (decel_px > thr_pix) begin
            saw_decel[it.camera] = 1'b1;
            decel_age[it.camera] = '0;
          end
        end
        stop_px  = '0;
        decel_px = '0;
      end
      default: begin
        if (it.camera < NUM_CAMERAS) begin
          hold_stop  = stop_age[it.camera] < hold_len;
          hold_decel = !hold_stop && (decel_age[it.camera] < hold_len);
          v.result_camera = it.camera;
          v.level         = hold_stop ? LVL_STOP : (hold_decel ? LVL_DECEL : LVL_SAFE);
          v.level_changed = v.level != last_level[it.camera];
          v.snapshot      = (v.level == LVL_STOP && last_level[it.camera] != LVL_STOP &&
                             saw_stop[it.camera]) ||
                            (v.level == LVL_DECEL && last_level[it.camera] == LVL_SAFE &&
                             saw_decel[it.camera]);
          v.stop_hit      = saw_stop[it.camera];
          v.decel_hit     = saw_decel[it.camera];
          verdicts_due.push_back(v);
          last_level[it.camera] = v.level;
          saw_stop[it.camera]   = 1'b0;
          saw_decel[it.camera]  = 1'b0;
        end
      end
    endcase
  endtask

  task automatic check_field(input string what, input logic [1:0] want_v, input logic [1:0] got_v);
    if (want_v !== got_v) begin
      fails++;
      $display("%0t: %s expected %0d, got %0d", $time, what, want_v, got_v);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Item driver: pop the next beat, hold it while stalled, idle between beats.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    logic  send;
    item_t next_beat;
    send      = item_valid;
    next_beat = item;
    cycle_no <= cycle_no + 1;
    if (item_valid && !item_stall) begin
      send     = 1'b0;
      gap_left = pause_len();
    end
    if (!send && !rst) begin
      if (gap_left > 0) begin
        gap_left--;
      end else if (pending.size() != 0) begin
        next_beat = pending.pop_front();
        send      = 1'b1;
      end
    end
    item_valid <= send;
    item       <= next_beat;
  end

  // ---------------------------------------------------------------------------
  // Monitor: check each accepted verdict against the oldest prediction, feed
  // each accepted item beat to the predictor, stall the result side at random
  // and watch for a hung channel.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    result_t want;
    logic    moved;
    moved = 1'b0;
    if (!rst) begin
      // check before predicting so a verdict can never match its own beat
      if (result_valid && !result_stall) begin
        moved = 1'b1;
        if (verdicts_due.size() == 0) begin
          fails++;
          $display("%0t: verdict %h arrived with none predicted", $time, result);
        end else begin
          want = verdicts_due.pop_front();
          verdicts_checked++;
          if (want.level == LVL_STOP) stop_verdicts++;
          if (want.level == LVL_DECEL) decel_verdicts++;
          if (want.snapshot) snapshots++;
          check_field("result_camera", want.result_camera, result.result_camera);
          check_field("level", want.level, result.level);
          check_field("snapshot", 2'(want.snapshot), 2'(result.snapshot));
          check_field("level_changed", 2'(want.level_changed), 2'(result.level_changed));
          check_field("stop_hit", 2'(want.stop_hit), 2'(result.stop_hit));
          check_field("decel_hit", 2'(want.decel_hit), 2'(result.decel_hit));
        end
      end
      if (item_valid && !item_stall) begin
        moved = 1'b1;
        items_taken++;
        judge_item(item);
      end
      idle_run = moved ? 0 : idle_run + 1;
      if (idle_run == IDLE_LIMIT) begin
        $display("%0t: no beat moved for %0d cycles", $time, IDLE_LIMIT);
        $display("zone_intrusion_alarm: mismatch");
        $finish;
      end
    end
    stall_left = (stall_left > 0) ? stall_left - 1 : pause_len();
    result_stall <= (stall_left != 0);
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers: fields the block ignores for a beat are left random.
  // ---------------------------------------------------------------------------
  function automatic item_t random_item();
    logic [ITEM_W-1:0] raw;
    item_t it;
    raw = ITEM_W'({$urandom(), $urandom()});
    it  = item_t'(raw);
    if (it.confidence > 11'd1024) it.confidence = 11'($urandom_range(0, 1024));
    return it;
  endfunction

  task automatic add_tick();
    item_t it;
    it      = random_item();
    it.func = FN_TICK;
    pending.push_back(it);
  endtask

  task automatic add_pixel(input logic zs, input logic zd, input logic [MASK_W-1:0] m);
    item_t it;
    it               = random_item();
    it.func          = FN_PIXEL;
    it.in_stop_zone  = zs;
    it.in_decel_zone = zd;
    it.mask_value    = m;
    pending.push_back(it);
  endtask

  task automatic add_target_end(input logic [CAM_W-1:0] cam, input logic [CONF_W-1:0] conf,
                                input logic [BOX_W-1:0] bw, input logic [BOX_W-1:0] bh,
                                input logic fits);
    item_t it;
    it               = random_item();
    it.func          = FN_END_TARGET;
    it.camera        = cam;
    it.confidence    = conf;
    it.box_width     = bw;
    it.box_height    = bh;
    it.mask_fits_box = fits;
    pending.push_back(it);
  endtask

  task automatic add_frame_end(input logic [CAM_W-1:0] cam);
    item_t it;
    it        = random_item();
    it.func   = FN_END_FRAME;
    it.camera = cam;
    pending.push_back(it);
  endtask

  // One well-formed frame: up to three targets, near the pixel threshold unless it
  // is large, some ticks to age the hold timers, then the frame end.
  task automatic add_frame();
    int               cam;
    int               ntgt;
    int               npx;
    int               kind;
    logic             zs;
    logic             zd;
    logic [CONF_W-1:0] conf;
    logic [BOX_W-1:0] bw;
    logic [BOX_W-1:0] bh;
    cam  = $urandom_range(0, NUM_CAMERAS - 1);
    ntgt = $urandom_range(0, 3);
    for (int t = 0; t < ntgt; t++) begin
      kind = $urandom_range(0, 2);
      if (thr_pix <= 8) npx = $urandom_range(0, thr_pix + 4);
      else if (thr_pix <= 200) npx = $urandom_range(thr_pix - 5, thr_pix + 25);
      else npx = $urandom_range(0, 6);
      for (int p = 0; p < npx; p++) begin
        // stop-heavy, decel-heavy or scattered targets
        case (kind)
          0:       begin zs = $urandom_range(0, 19) != 0; zd = $urandom_range(0, 1); end
          1:       begin zs = $urandom_range(0, 19) == 0; zd = $urandom_range(0, 19) != 0; end
          default: begin zs = $urandom_range(0, 1); zd = $urandom_range(0, 1); end
        endcase
        add_pixel(zs, zd, ($urandom_range(0, 9) != 0) ? 8'($urandom_range(128, 255))
                                                      : 8'($urandom_range(0, 127)));
      end
      conf = ($urandom_range(0, 4) != 0) ? 11'($urandom_range(thr_conf, 1024))
                                         : 11'($urandom_range(0, 1024));
      bw = ($urandom_range(0, 9) != 0) ? 12'($urandom_range(15, 4095)) : 12'($urandom_range(0, 15));
      bh = ($urandom_range(0, 9) != 0) ? 12'($urandom_range(15, 4095)) : 12'($urandom_range(0, 15));
      add_target_end(($urandom_range(0, 4) != 0) ? 2'(cam) : 2'($urandom_range(0, 3)),
                     conf, bw, bh, $urandom_range(0, 9) != 0);
    end
    repeat ((hold_len <= 40) ? $urandom_range(0, hold_len / 2 + 1) : $urandom_range(0, 2))
      add_tick();
    add_frame_end(2'(cam));
  endtask

  // Mostly well-formed frames, some tick bursts, the rest raw noise
  task automatic random_phase(input int budget);
    int r;
    while (pending.size() < budget) begin
      r = $urandom_range(0, 99);
      if (r < 65) begin
        add_frame();
      end else if (r < 80) begin
        repeat ($urandom_range(1, (hold_len <= 40) ? hold_len + 2 : 4)) add_tick();
      end else begin
        pending.push_back(random_item());
      end
    end
  endtask

  // Wait until every beat is sent and every predicted verdict has come back
  task automatic drain();
    do @(negedge clk);
    while (pending.size() != 0 || item_valid || verdicts_due.size() != 0);
  endtask

  task automatic set_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= val;
    @(posedge clk);
    case (idx)
      CFG_CONF_THR: thr_conf = val[CONF_W-1:0];
      CFG_PIX_THR:  thr_pix  = val[PIX_THR_W-1:0];
      default:      hold_len = val[HOLD_W-1:0];
    endcase
  endtask

  // Write all three registers once the block has gone quiet
  task automatic load_settings(input int conf, input int pix, input int hold);
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    set_reg(CFG_CONF_THR, CFG_DATA_W'(conf));
    set_reg(CFG_PIX_THR, CFG_DATA_W'(pix));
    set_reg(CFG_HOLD, CFG_DATA_W'(hold));
    wr_en <= 1'b0;
    @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Sequence: reset, a directed frame set, then random phases over several
  // register settings including the extremes.
  // ---------------------------------------------------------------------------
  initial begin
    thr_conf = CONF_THR_RST;
    thr_pix  = PIX_THR_RST;
    hold_len = HOLD_RST;
    stop_px  = '0;
    decel_px = '0;
    for (int k = 0; k < NUM_CAMERAS; k++) begin
      stop_age[k]   = '1;
      decel_age[k]  = '1;
      last_level[k] = LVL_SAFE;
      saw_stop[k]   = 1'b0;
      saw_decel[k]  = 1'b0;
    end
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: any single set pixel intrudes, alarms hold for two ticks
    load_settings(512, 0, 2);
    add_frame_end(2'd0);                             // timers start far past: safe
    add_pixel(1'b1, 1'b1, 8'd127);                   // mask at the limit is not set
    add_target_end(2'd0, 11'd1024, 12'd15, 12'd15, 1'b1);
    add_pixel(1'b1, 1'b1, 8'd128);                   // both zones: stop wins
    add_target_end(2'd1, 11'd512, 12'd4095, 12'd4095, 1'b1);
    add_frame_end(2'd1);                             // stop raised with snapshot
    add_pixel(1'b0, 1'b1, 8'd255);
    add_target_end(2'd2, 11'd1024, 12'd15, 12'd4095, 1'b1);
    add_frame_end(2'd2);                             // decel raised with snapshot
    add_pixel(1'b1, 1'b0, 8'd200);
    add_target_end(2'd3, 11'd511, 12'd100, 12'd100, 1'b1);   // confidence just short
    add_pixel(1'b1, 1'b0, 8'd200);
    add_target_end(2'd3, 11'd900, 12'd14, 12'd100, 1'b1);    // box too narrow
    add_pixel(1'b1, 1'b0, 8'd200);
    add_target_end(2'd3, 11'd900, 12'd100, 12'd14, 1'b1);    // box too short
    add_pixel(1'b1, 1'b0, 8'd200);
    add_target_end(2'd3, 11'd900, 12'd100, 12'd100, 1'b0);   // mask does not fit
    add_frame_end(2'd3);                             // nothing qualified: safe
    add_pixel(1'b0, 1'b1, 8'd255);
    add_target_end(2'd1, 11'd600, 12'd20, 12'd20, 1'b1);
    add_frame_end(2'd1);                             // decel hit under a held stop
    add_tick();
    add_tick();
    add_frame_end(2'd1);                             // hold expired: back to safe
    add_frame_end(2'd2);

    load_settings(0, 0, 1);
    random_phase(200);
    load_settings(1024, 3, 0);                       // a zero hold never alarms
    random_phase(200);
    load_settings(CONF_THR_RST, PIX_THR_RST, HOLD_RST);
    random_phase(250);
    load_settings(300, 24'hFF_FFFF, 16'hFFFF);       // no count can exceed this
    random_phase(150);
    load_settings(700, 2, 16'hFFFF);
    random_phase(200);
    repeat (3) begin
      load_settings($urandom_range(0, 1024), $urandom_range(0, 6), $urandom_range(1, 40));
      random_phase(200);
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("%0d item beats over nine register settings, %0d verdicts checked",
             items_taken, verdicts_checked);
    $display("verdicts: %0d stop, %0d decel, %0d with snapshot",
             stop_verdicts, decel_verdicts, snapshots);
    if (fails == 0) $display("zone_intrusion_alarm: match");
    else $display("zone_intrusion_alarm: mismatch");
    $finish;
  end

endmodule

[files.f]
rtl/zia_pkg.sv
rtl/zone_intrusion_alarm.sv
tb/zone_intrusion_alarm_test.sv
